### src/hrms_pkg.sv
package hrms_pkg;

  // Fixed field widths
  localparam int RATE_W   = 16;
  localparam int SMOOTH_W = 24;
  localparam int CNT_W    = 8;
  localparam int BIT_W    = 4;
  localparam int CFG_IDX_W = 3;

  // Register reset values
  localparam logic [RATE_W-1:0] GATE_LOW_RST   = 16'd8960;
  localparam logic [RATE_W-1:0] GATE_HIGH_RST  = 16'd46080;
  localparam logic [RATE_W-1:0] STEP_LIMIT_RST = 16'd384;
  localparam logic [RATE_W-1:0] GAIN_RST       = 16'd9830;
  localparam logic [RATE_W-1:0] LOW_LEVEL_RST  = 16'd12800;
  localparam logic [RATE_W-1:0] HIGH_LEVEL_RST = 16'd30720;
  localparam logic [CNT_W-1:0]  DEBOUNCE_RST   = 8'd8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATE_LOW        = 3'd0,
    REG_GATE_HIGH       = 3'd1,
    REG_STEP_LIMIT      = 3'd2,
    REG_SMOOTHING_GAIN  = 3'd3,
    REG_LOW_RATE_LEVEL  = 3'd4,
    REG_HIGH_RATE_LEVEL = 3'd5,
    REG_DEBOUNCE_LIMIT  = 3'd6
  } cfg_reg_t;

  // Output status codes
  typedef enum logic [2:0] {
    ST_WAITING     = 3'd0,
    ST_LOW         = 3'd1,
    ST_HIGH        = 3'd2,
    ST_NORMAL      = 3'd3,
    ST_LEAD_FAULT  = 3'd4
  } rate_status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SINIT,
    S_SEL,
    S_DIFF,
    S_MUL,
    S_UPD,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic ld_item;
    logic step_db;
    logic clr_filt;
    logic wr_hist;
    logic sel_init;
    logic sel_step;
    logic calc_diff;
    logic calc_mul;
    logic calc_upd;
    logic ld_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_clear;
    logic off_step;
    logic rate_ok;
    logic sel_last;
  } sts_t;

endpackage

### src/hrms_ctrl.sv
module hrms_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  hrms_pkg::sts_t    sts,
  output hrms_pkg::cmd_t    cmd
);

  hrms_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hrms_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      hrms_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          state_nxt   = hrms_pkg::S_EVAL;
        end
      end
      hrms_pkg::S_EVAL: begin
        if (sts.is_clear) begin
          cmd.clr_filt = 1'b1;
          state_nxt    = hrms_pkg::S_DONE;
        end else begin
          cmd.step_db = 1'b1;
          if (sts.off_step) begin
            cmd.clr_filt = 1'b1;
            state_nxt    = hrms_pkg::S_DONE;
          end else if (sts.rate_ok) begin
            cmd.wr_hist = 1'b1;
            state_nxt   = hrms_pkg::S_SINIT;
          end else begin
            state_nxt = hrms_pkg::S_DONE;
          end
        end
      end
      hrms_pkg::S_SINIT: begin
        cmd.sel_init = 1'b1;
        state_nxt    = hrms_pkg::S_SEL;
      end
      hrms_pkg::S_SEL: begin
        cmd.sel_step = 1'b1;
        if (sts.sel_last) state_nxt = hrms_pkg::S_DIFF;
      end
      hrms_pkg::S_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_nxt     = hrms_pkg::S_MUL;
      end
      hrms_pkg::S_MUL: begin
        cmd.calc_mul = 1'b1;
        state_nxt    = hrms_pkg::S_UPD;
      end
      hrms_pkg::S_UPD: begin
        cmd.calc_upd = 1'b1;
        state_nxt    = hrms_pkg::S_DONE;
      end
      hrms_pkg::S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.ld_out = 1'b1;
          state_nxt  = hrms_pkg::S_IDLE;
        end
      end
      default: state_nxt = hrms_pkg::S_IDLE;
    endcase

    if (cmd.ld_out)      out_valid_nxt = 1'b1;
    else if (out_ready)  out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule

### src/hrms_dp.sv
module hrms_dp #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [hrms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hrms_pkg::RATE_W-1:0]        cfg_wdata,
  input  logic                               in_func,
  input  logic                               in_lead_off_pin,
  input  logic [hrms_pkg::RATE_W-1:0]        in_beat_rate,
  input  hrms_pkg::cmd_t                     cmd,
  output hrms_pkg::sts_t                     sts,
  output logic [hrms_pkg::RATE_W-1:0]        out_rate_out,
  output logic [2:0]                         out_rate_status,
  output logic                               out_lead_fault
);

  localparam int FW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [FW-1:0] FILL_MAX  = FW'(HISTORY_DEPTH);
  localparam logic [SW-1:0] SLOT_LAST = SW'(HISTORY_DEPTH - 1);
  localparam int RW = hrms_pkg::RATE_W;
  localparam int MW = hrms_pkg::SMOOTH_W;
  localparam int DW = MW + 2;            // signed difference
  localparam int PW = DW + RW + 1;       // signed product
  localparam int IW = PW - RW;           // increment after floor shift

  // Configuration registers
  logic [RW-1:0] gate_low_r, gate_high_r, step_limit_r, gain_r;
  logic [RW-1:0] low_level_r, high_level_r;
  logic [hrms_pkg::CNT_W-1:0] db_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_low_r   <= hrms_pkg::GATE_LOW_RST;
      gate_high_r  <= hrms_pkg::GATE_HIGH_RST;
      step_limit_r <= hrms_pkg::STEP_LIMIT_RST;
      gain_r       <= hrms_pkg::GAIN_RST;
      low_level_r  <= hrms_pkg::LOW_LEVEL_RST;
      high_level_r <= hrms_pkg::HIGH_LEVEL_RST;
      db_limit_r   <= hrms_pkg::DEBOUNCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hrms_pkg::REG_GATE_LOW:        gate_low_r   <= cfg_wdata;
        hrms_pkg::REG_GATE_HIGH:       gate_high_r  <= cfg_wdata;
        hrms_pkg::REG_STEP_LIMIT:      step_limit_r <= cfg_wdata;
        hrms_pkg::REG_SMOOTHING_GAIN:  gain_r       <= cfg_wdata;
        hrms_pkg::REG_LOW_RATE_LEVEL:  low_level_r  <= cfg_wdata;
        hrms_pkg::REG_HIGH_RATE_LEVEL: high_level_r <= cfg_wdata;
        hrms_pkg::REG_DEBOUNCE_LIMIT:  db_limit_r   <= cfg_wdata[hrms_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured input beat
  logic          func_r, pin_r;
  logic [RW-1:0] rate_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      func_r <= in_func;
      pin_r  <= in_lead_off_pin;
      rate_r <= in_beat_rate;
    end
  end

  // Leads-off debounce counter, saturating at the limit and at zero
  logic [hrms_pkg::CNT_W-1:0] cnt_r, cnt_step;

  always_comb begin
    cnt_step = cnt_r;
    if (pin_r) begin
      if (cnt_r < db_limit_r) cnt_step = cnt_r + 1'b1;
    end else if (cnt_r != '0) begin
      cnt_step = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)           cnt_r <= '0;
    else if (cmd.step_db) cnt_r <= cnt_step;
  end

  assign sts.is_clear = func_r;
  assign sts.off_step = (cnt_step >= db_limit_r);
  assign sts.rate_ok  = (rate_r != '0) && (rate_r >= gate_low_r) && (rate_r <= gate_high_r);

  // Rate history ring; only the first fill_r lanes are ever read
  logic [RW-1:0] hist_r [HISTORY_DEPTH];
  logic [SW-1:0] slot_r;
  logic [FW-1:0] fill_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_hist) hist_r[slot_r] <= rate_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_filt) begin
      slot_r <= '0;
      fill_r <= '0;
    end else if (cmd.wr_hist) begin
      slot_r <= (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
      if (fill_r != FILL_MAX) fill_r <= fill_r + 1'b1;
    end
  end

  // Median by bitwise rank select, MSB first, one bit per cycle
  logic [HISTORY_DEPTH-1:0] cand_r, plane, zmask;
  logic [FW-1:0]            k_r, zeros;
  logic [hrms_pkg::BIT_W-1:0] bit_r;
  logic [RW-1:0]            med_r;

  always_comb begin
    zeros = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      plane[i] = hist_r[i][bit_r];
      zmask[i] = cand_r[i] & ~plane[i];
      zeros    = zeros + FW'(zmask[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel_init) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        cand_r[i] <= (FW'(i) < fill_r);
      end
      k_r   <= fill_r >> 1;
      bit_r <= hrms_pkg::BIT_W'(RW - 1);
    end else if (cmd.sel_step) begin
      if (k_r < zeros) begin
        cand_r       <= zmask;
        med_r[bit_r] <= 1'b0;
      end else begin
        cand_r       <= cand_r & plane;
        k_r          <= k_r - zeros;
        med_r[bit_r] <= 1'b1;
      end
      bit_r <= bit_r - 1'b1;
    end
  end

  assign sts.sel_last = (bit_r == '0);

  // Clamped difference, product, then floored update
  logic [MW-1:0]        sm_r;
  logic                 primed_r;
  logic signed [DW-1:0] diff_w, lim_w, diff_r;
  logic signed [PW-1:0] prod_w, prod_r;
  logic signed [IW-1:0] inc_w;
  logic signed [MW+3:0] sum_w;
  logic [MW-1:0]        sm_upd;

  always_comb begin
    diff_w = $signed({2'b00, med_r, 8'h00}) - $signed({2'b00, sm_r});
    lim_w  = $signed({2'b00, step_limit_r, 8'h00});
    if (diff_w > lim_w)       diff_w = lim_w;
    else if (diff_w < -lim_w) diff_w = -lim_w;
  end

  assign prod_w = diff_r * $signed({1'b0, gain_r});
  assign inc_w  = prod_r[PW-1:RW];

  always_comb begin
    sum_w = $signed({4'b0000, sm_r}) + $signed({{(MW+4-IW){inc_w[IW-1]}}, inc_w});
    if (sum_w[MW+3])               sm_upd = '0;
    else if (sum_w[MW+2:MW] != '0) sm_upd = '1;
    else                           sm_upd = sum_w[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_diff) diff_r <= diff_w;
    if (cmd.calc_mul)  prod_r <= prod_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_filt) begin
      sm_r     <= '0;
      primed_r <= 1'b0;
    end else if (cmd.calc_upd) begin
      primed_r <= 1'b1;
      sm_r     <= primed_r ? sm_upd : {med_r, 8'h00};
    end
  end

  // Result register
  logic [RW-1:0] rate_q;
  logic          off_now;
  logic [2:0]    status_w;

  assign rate_q  = sm_r[MW-1:8];
  assign off_now = (cnt_r >= db_limit_r);

  always_comb begin
    if (off_now)                     status_w = hrms_pkg::ST_LEAD_FAULT;
    else if (rate_q == '0)           status_w = hrms_pkg::ST_WAITING;
    else if (rate_q < low_level_r)   status_w = hrms_pkg::ST_LOW;
    else if (rate_q > high_level_r)  status_w = hrms_pkg::ST_HIGH;
    else                             status_w = hrms_pkg::ST_NORMAL;
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_rate_out    <= rate_q;
      out_rate_status <= status_w;
      out_lead_fault  <= off_now;
    end
  end

endmodule

### src/heart_rate_median_slew_smoother.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_func, in_lead_off_pin, in_beat_rate
// out       out_valid / out_ready  out_rate_out, out_rate_status, out_lead_fault
// cfg       cfg_we                 cfg_index, cfg_wdata
//
// One beat at a time. For a beat whose rate enters the history, the controller runs the
// evaluate and select setup states, the 16-step bitwise median select (one rate bit per
// cycle), then the difference, multiply, update and load stages before out_valid rises;
// other beats go from evaluate straight to load. The next beat is taken in the cycle
// after the result is loaded.
// Reset (rst_n low, synchronous) restores the register defaults and clears the filter.
// A held result does not block acceptance of the next beat, but that beat's result
// waits in the controller until the output register frees up.
module heart_rate_median_slew_smoother #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic                           in_lead_off_pin,
  input  logic [hrms_pkg::RATE_W-1:0]    in_beat_rate,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hrms_pkg::RATE_W-1:0]    out_rate_out,
  output logic [2:0]                     out_rate_status,
  output logic                           out_lead_fault,
  input  logic                           cfg_we,
  input  logic [hrms_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hrms_pkg::RATE_W-1:0]    cfg_wdata
);

  hrms_pkg::cmd_t cmd;
  hrms_pkg::sts_t sts;

  hrms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  hrms_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_func         (in_func),
    .in_lead_off_pin (in_lead_off_pin),
    .in_beat_rate    (in_beat_rate),
    .cmd             (cmd),
    .sts             (sts),
    .out_rate_out    (out_rate_out),
    .out_rate_status (out_rate_status),
    .out_lead_fault  (out_lead_fault)
  );

endmodule

### src/hrms_checker.sv
module hrms_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_func,
  input logic                           in_lead_off_pin,
  input logic [hrms_pkg::RATE_W-1:0]    in_beat_rate,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [hrms_pkg::RATE_W-1:0]    out_rate_out,
  input logic [2:0]                     out_rate_status,
  input logic                           out_lead_fault,
  input logic                           cfg_we,
  input logic [hrms_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [hrms_pkg::RATE_W-1:0]    cfg_wdata
);

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rate_out) &&
    $stable(out_rate_status) && $stable(out_lead_fault))
    else $error("result beat changed while stalled");

  // Leads off forces a zero rate and the leads-off status
  a_lead_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lead_fault |->
    out_rate_out == '0 && out_rate_status == hrms_pkg::ST_LEAD_FAULT)
    else $error("leads-off result not cleared");

  // With leads on, waiting status goes with a zero rate and nothing else
  a_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_lead_fault |->
    (out_rate_out == '0) == (out_rate_status == hrms_pkg::ST_WAITING))
    else $error("waiting status does not match zero rate");

  // Leads-off status only with the leads-off flag
  a_status_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rate_status == hrms_pkg::ST_LEAD_FAULT |-> out_lead_fault)
    else $error("leads-off status without flag");

  // No result right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind heart_rate_median_slew_smoother hrms_checker u_hrms_checker (.*);
